// File: rtl/sts_pkg.sv
// Shared types and helpers for the sphere triangle subdivider.
`timescale 1ns / 1ps
`default_nettype none
package sts_pkg;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    vec_t a;
    vec_t b;
    vec_t c;
  } tri_t;

  // One queued triangle with its classification.
  typedef struct packed {
    tri_t       t;
    logic [1:0] start;
    logic [1:0] top;
    logic       single;
  } item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // Back end status toward the top level.
  typedef struct packed {
    logic       busy;
  } bk_stat_t;

  localparam logic [2:0] CFG_ADDR_RADIUS = 3'd0;
  localparam logic [2:0] CFG_ADDR_LEVEL  = 3'd4;
  localparam logic [30:0] RADIUS_RESET   = 31'd227687629;
  localparam logic [1:0]  LEVEL_RESET    = 2'd3;

  function automatic coord_t mid_half(input coord_t p, input coord_t q);
    logic signed [32:0] s;
    s = {p[31], p} + {q[31], q};
    return s[32:1];
  endfunction

  function automatic logic [31:0] mag32(input coord_t v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic coord_t sub_sat(input coord_t q, input coord_t p);
    logic signed [32:0] d;
    d = {q[31], q} - {p[31], p};
    if (d[32] != d[31]) return d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return d[31:0];
  endfunction

  // Children in depth-first order: (a,B,C), (A,b,C), (A,B,c), (C,B,A).
  function automatic tri_t child_tri(input tri_t t, input tri_t m, input logic [1:0] k);
    tri_t r;
    unique case (k)
      2'd0: r = '{a: t.a, b: m.b, c: m.c};
      2'd1: r = '{a: m.a, b: t.b, c: m.c};
      2'd2: r = '{a: m.a, b: m.b, c: t.c};
      default: r = '{a: m.c, b: m.b, c: m.a};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/sts_in_if.sv
// Input channel: one triangle and its starting level.
`timescale 1ns / 1ps
`default_nettype none
interface sts_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  ax;
  logic signed [31:0]  ay;
  logic signed [31:0]  az;
  logic signed [31:0]  bx;
  logic signed [31:0]  by_coord;
  logic signed [31:0]  bz;
  logic signed [31:0]  cx;
  logic signed [31:0]  cy;
  logic signed [31:0]  cz;
  logic [1:0]          start_level;

  modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, start_level,
                  input ready);
  modport sink   (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, start_level,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/sts_out_if.sv
// Result channel: one leaf cell.
`timescale 1ns / 1ps
`default_nettype none
interface sts_out_if;
  logic                valid;
  logic                ready;
  logic [1:0]          cell_level;
  logic signed [31:0]  origin_x;
  logic signed [31:0]  origin_y;
  logic signed [31:0]  origin_z;
  logic signed [31:0]  edge1_x;
  logic signed [31:0]  edge1_y;
  logic signed [31:0]  edge1_z;
  logic signed [31:0]  edge2_x;
  logic signed [31:0]  edge2_y;
  logic signed [31:0]  edge2_z;
  logic                last_cell;

  modport source (output valid, cell_level, origin_x, origin_y, origin_z, edge1_x, edge1_y,
                  edge1_z, edge2_x, edge2_y, edge2_z, last_cell, input ready);
  modport sink   (input valid, cell_level, origin_x, origin_y, origin_z, edge1_x, edge1_y,
                  edge1_z, edge2_x, edge2_y, edge2_z, last_cell, output ready);
endinterface
`default_nettype wire

// File: rtl/sts_front.sv
// Front end: accepts triangles, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module sts_front import sts_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sts_in_if.sink      in_ch,
  input  wire logic [1:0] top_eff,
  input  wire logic   pop,
  output q_head_t     head
);

  item_t      slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       push;
  item_t      item_in;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    item_in.t.a    = '{x: in_ch.ax, y: in_ch.ay, z: in_ch.az};
    item_in.t.b    = '{x: in_ch.bx, y: in_ch.by_coord, z: in_ch.bz};
    item_in.t.c    = '{x: in_ch.cx, y: in_ch.cy, z: in_ch.cz};
    item_in.start  = in_ch.start_level;
    item_in.top    = top_eff;
    // already at or past the stop level: emitted as it is
    item_in.single = (in_ch.start_level >= top_eff);
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= item_in;
  end

endmodule
`default_nettype wire

// File: rtl/sts_mid.sv
// Midpoint unit: edge midpoint scaled onto the shell, via serial square root and divider.
`timescale 1ns / 1ps
`default_nettype none
module sts_mid import sts_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire vec_t        p,
  input  wire vec_t        q,
  input  wire logic [30:0] radius,
  output logic             done,
  output vec_t             r
);

  typedef enum logic [6:0] {
    M_IDLE  = 7'b0000001,
    M_SQ    = 7'b0000010,
    M_ROOT  = 7'b0000100,
    M_MUL   = 7'b0001000,
    M_DIV   = 7'b0010000,
    M_STORE = 7'b0100000,
    M_DONE  = 7'b1000000
  } mstate_t;

  mstate_t     state_r;
  coord_t      m_r [3];
  logic [1:0]  cidx_r;
  logic [4:0]  cnt_r;
  logic [63:0] sum_r;
  logic [31:0] root_r;
  logic [32:0] rem_r;
  logic [31:0] drem_r;
  logic [30:0] dnum_r;
  logic [30:0] quo_r;
  vec_t        r_r;

  logic [31:0] mag;
  logic [63:0] sq;
  logic [63:0] prod;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic [32:0] dsh;
  coord_t      sres;

  assign mag    = mag32(m_r[cidx_r]);
  assign sq     = mag * mag;
  assign prod   = mag * {1'b0, radius};
  assign rem_sh = {rem_r, sum_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign dsh    = {drem_r, dnum_r[30]};
  assign sres   = m_r[cidx_r][31] ? (32'sd0 - $signed({1'b0, quo_r}))
                                  : $signed({1'b0, quo_r});

  assign done = (state_r == M_DONE);
  assign r    = r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      cidx_r  <= 2'd0;
      cnt_r   <= 5'd0;
    end else begin
      unique case (state_r)
        M_IDLE: if (go) begin
          state_r <= M_SQ;
          cidx_r  <= 2'd0;
        end
        M_SQ: begin
          cidx_r <= (cidx_r == 2'd2) ? 2'd0 : cidx_r + 2'd1;
          if (cidx_r == 2'd2) begin
            state_r <= M_ROOT;
            cnt_r   <= 5'd0;
          end
        end
        M_ROOT: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) state_r <= M_MUL;
        end
        M_MUL: begin
          cnt_r   <= 5'd0;
          // zero-length midpoint: result stays the zero vector
          state_r <= (root_r == 32'd0) ? M_DONE : M_DIV;
        end
        M_DIV: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd30) state_r <= M_STORE;
        end
        M_STORE: begin
          if (cidx_r == 2'd2) begin
            state_r <= M_DONE;
            cidx_r  <= 2'd0;
          end else begin
            state_r <= M_MUL;
            cidx_r  <= cidx_r + 2'd1;
          end
        end
        M_DONE: state_r <= M_IDLE;
        default: state_r <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      M_IDLE: if (go) begin
        m_r[0] <= mid_half(p.x, q.x);
        m_r[1] <= mid_half(p.y, q.y);
        m_r[2] <= mid_half(p.z, q.z);
        sum_r  <= 64'd0;
        root_r <= 32'd0;
        rem_r  <= 33'd0;
      end
      M_SQ: sum_r <= sum_r + sq;
      M_ROOT: begin
        sum_r <= {sum_r[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= 33'(rem_sh - trial);
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[32:0];
          root_r <= {root_r[30:0], 1'b0};
        end
      end
      M_MUL: begin
        if (root_r == 32'd0) r_r <= '0;
        // quotient fits 31 bits, so the top half already lies below the divisor
        drem_r <= {1'b0, prod[61:31]};
        dnum_r <= prod[30:0];
        quo_r  <= 31'd0;
      end
      M_DIV: begin
        dnum_r <= {dnum_r[29:0], 1'b0};
        if (dsh >= {1'b0, root_r}) begin
          drem_r <= 32'(dsh - {1'b0, root_r});
          quo_r  <= {quo_r[29:0], 1'b1};
        end else begin
          drem_r <= dsh[31:0];
          quo_r  <= {quo_r[29:0], 1'b0};
        end
      end
      M_STORE: begin
        unique case (cidx_r)
          2'd0:    r_r.x <= sres;
          2'd1:    r_r.y <= sres;
          default: r_r.z <= sres;
        endcase
      end
      M_DONE: ;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/sts_back.sv
// Back end: depth-first subdivision sequencer and leaf output register.
`timescale 1ns / 1ps
`default_nettype none
module sts_back import sts_pkg::*; #(
  parameter int MAX_DEPTH = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire q_head_t     head,
  output logic             pop,
  input  wire logic [30:0] radius,
  output bk_stat_t         stat,
  sts_out_if.source        out_ch
);

  localparam int NLVL = MAX_DEPTH + 1;
  localparam int LW   = (NLVL > 1) ? $clog2(NLVL) : 1;

  typedef enum logic [7:0] {
    B_IDLE   = 8'b00000001,
    B_NODE   = 8'b00000010,
    B_MGO    = 8'b00000100,
    B_MWAIT  = 8'b00001000,
    B_DESC   = 8'b00010000,
    B_POP    = 8'b00100000,
    B_CHK    = 8'b01000000,
    B_EMIT   = 8'b10000000
  } bstate_t;

  bstate_t    state_r;
  logic [1:0] d_r;
  logic [1:0] s_lvl_r;
  logic [1:0] top_r;
  logic [1:0] midx_r;
  tri_t       tri_r   [NLVL];
  tri_t       mid_r   [NLVL];
  logic [1:0] child_r [NLVL];
  logic       lastp_r [NLVL];
  tri_t       lv_r;
  logic [1:0] lv_level_r;
  logic       lv_last_r;
  logic       ov_r;

  logic [LW-1:0] di;
  logic [1:0]    dn;
  tri_t          cur;
  vec_t          mp;
  vec_t          mq;
  logic          mgo;
  logic          mdone;
  vec_t          mres;
  logic          emit_ok;

  assign di      = d_r[LW-1:0];
  assign dn      = d_r + 2'd1;
  assign cur     = tri_r[di];
  assign pop     = (state_r == B_IDLE) && head.valid;
  assign mgo     = (state_r == B_MGO);
  assign emit_ok = !ov_r || out_ch.ready;

  assign stat.busy  = (state_r != B_IDLE);

  always_comb begin
    unique case (midx_r)
      2'd0:    begin mp = cur.b; mq = cur.c; end
      2'd1:    begin mp = cur.c; mq = cur.a; end
      default: begin mp = cur.a; mq = cur.b; end
    endcase
  end

  sts_mid u_mid (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (mgo),
    .p      (mp),
    .q      (mq),
    .radius (radius),
    .done   (mdone),
    .r      (mres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      d_r     <= 2'd0;
      s_lvl_r <= 2'd0;
      top_r   <= 2'd0;
      midx_r  <= 2'd0;
      ov_r    <= 1'b0;
    end else begin
      // drop valid after the transfer unless a new cell is loaded
      if (ov_r && out_ch.ready && !(state_r == B_EMIT && emit_ok)) ov_r <= 1'b0;
      unique case (state_r)
        B_IDLE: if (head.valid) begin
          d_r     <= head.item.start;
          s_lvl_r <= head.item.start;
          top_r   <= head.item.top;
          state_r <= head.item.single ? B_EMIT : B_NODE;
        end
        B_NODE: begin
          midx_r  <= 2'd0;
          state_r <= (d_r >= top_r) ? B_EMIT : B_MGO;
        end
        B_MGO: state_r <= B_MWAIT;
        B_MWAIT: if (mdone) begin
          midx_r  <= midx_r + 2'd1;
          state_r <= (midx_r == 2'd2) ? B_DESC : B_MGO;
        end
        B_DESC: begin
          d_r     <= dn;
          state_r <= B_NODE;
        end
        B_POP: begin
          if (d_r == s_lvl_r) state_r <= B_IDLE;
          else begin
            d_r     <= d_r - 2'd1;
            state_r <= B_CHK;
          end
        end
        B_CHK: state_r <= (child_r[di] == 2'd3) ? B_POP : B_DESC;
        B_EMIT: if (emit_ok) begin
          ov_r    <= 1'b1;
          state_r <= B_POP;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: if (head.valid) begin
        if (head.item.single) begin
          lv_r       <= head.item.t;
          lv_level_r <= head.item.start;
          lv_last_r  <= 1'b1;
        end else begin
          tri_r[head.item.start[LW-1:0]]   <= head.item.t;
          lastp_r[head.item.start[LW-1:0]] <= 1'b1;
        end
      end
      B_NODE: begin
        lv_r       <= cur;
        lv_level_r <= d_r;
        lv_last_r  <= lastp_r[di];
        child_r[di] <= 2'd0;
      end
      B_MGO: ;
      B_MWAIT: if (mdone) begin
        unique case (midx_r)
          2'd0:    mid_r[di].a <= mres;
          2'd1:    mid_r[di].b <= mres;
          default: mid_r[di].c <= mres;
        endcase
      end
      B_DESC: begin
        tri_r[dn[LW-1:0]]   <= child_tri(cur, mid_r[di], child_r[di]);
        lastp_r[dn[LW-1:0]] <= lastp_r[di] && (child_r[di] == 2'd3);
      end
      B_POP: ;
      // advance to the next sibling
      B_CHK: if (child_r[di] != 2'd3) child_r[di] <= child_r[di] + 2'd1;
      B_EMIT: if (emit_ok) begin
        out_ch.cell_level <= lv_level_r;
        out_ch.origin_x   <= lv_r.a.x;
        out_ch.origin_y   <= lv_r.a.y;
        out_ch.origin_z   <= lv_r.a.z;
        out_ch.edge1_x    <= sub_sat(lv_r.b.x, lv_r.a.x);
        out_ch.edge1_y    <= sub_sat(lv_r.b.y, lv_r.a.y);
        out_ch.edge1_z    <= sub_sat(lv_r.b.z, lv_r.a.z);
        out_ch.edge2_x    <= sub_sat(lv_r.c.x, lv_r.a.x);
        out_ch.edge2_y    <= sub_sat(lv_r.c.y, lv_r.a.y);
        out_ch.edge2_z    <= sub_sat(lv_r.c.z, lv_r.a.z);
        out_ch.last_cell  <= lv_last_r;
      end
      default: ;
    endcase
  end

  assign out_ch.valid = ov_r;

endmodule
`default_nettype wire

// File: rtl/sphere_triangle_subdivider.sv
// Top level: configuration registers, front end, back end and checks.
//
// in_ch takes one triangle (vertices a, b, c in Q15.16) and a starting level;
// out_ch returns its leaf cells in depth-first order, last_cell on the final one.
// A triangle at or past the stop level (max_level clamped to MAX_DEPTH) comes
// back unchanged as one cell. A triangle below it yields 4^(stop - start)
// cells. Each split costs three midpoints from one shared midpoint unit; a
// midpoint runs a 32-step square root once and a 31-step divider for each
// of three components. A full split from level 0 to 3 has 21 splits, 64 cells.
// A two-entry queue sits between the front and back ends, so up to two more
// triangles are taken while one is worked on; in_ch.ready drops when it is full.
// A stalled receiver holds the output register; the sequencer waits to emit.
// Registers via the cfg_ port: shell_radius at 0x0, max_level at 0x4; write
// only while idle. Synchronous reset empties the queue, idles the sequencer
// and restores the register reset values.
`timescale 1ns / 1ps
`default_nettype none
module sphere_triangle_subdivider import sts_pkg::*; #(
  parameter int MAX_DEPTH = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sts_in_if.sink           in_ch,
  sts_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [30:0] radius_r;
  logic [1:0]  level_r;
  logic [1:0]  top_eff;
  logic        cfg_wr;
  q_head_t     head;
  logic        pop;
  bk_stat_t    stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[2] ? {30'd0, level_r} : {1'b0, radius_r};
  assign top_eff    = (level_r > 2'(MAX_DEPTH)) ? 2'(MAX_DEPTH) : level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
      level_r  <= LEVEL_RESET;
    end else if (cfg_wr) begin
      // decode on the word index only
      if (cfg_paddr[2] == CFG_ADDR_LEVEL[2]) level_r  <= cfg_pwdata[1:0];
      else                                  radius_r <= cfg_pwdata[30:0];
    end
  end

  sts_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .top_eff (top_eff),
    .pop     (pop),
    .head    (head)
  );

  sts_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .radius (radius_r),
    .stat   (stat),
    .out_ch (out_ch)
  );

  // a cell that is not the last leaves the sequencer still busy
  a_more_cells: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_cell |-> stat.busy)
    else $error("non-final cell transferred with sequencer idle");

  // work starts only from a queued triangle
  a_start_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stat.busy) |-> $past(head.valid))
    else $error("sequencer started without a queued triangle");

  // a pop always starts the sequencer
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> stat.busy)
    else $error("queue popped but sequencer did not start");

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the sphere triangle subdivider.
`timescale 1ns / 1ps
module testbench;
  import sts_pkg::*;

  localparam int LIMIT_CYCLES = 12000000;
  localparam int STOP_DEPTH   = 3;
  localparam int PHASE_ITEMS  = 50;
  localparam int LONG_HOLD    = 3000;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } v3_t;

  typedef struct {
    logic [1:0]  lvl;
    logic [31:0] f[9];
    logic        last;
  } cell_t;

  class cell_scoreboard;
    cell_t       pending[$];
    int          errors;
    int          cells_seen;
    int          tris_seen;
    longint      radius;
    int          top;
    string       names[9] = '{"origin_x", "origin_y", "origin_z", "edge1_x", "edge1_y",
                              "edge1_z", "edge2_x", "edge2_y", "edge2_z"};

    function new();
      radius = longint'(RADIUS_RESET);
      top    = int'(LEVEL_RESET);
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned root64(longint unsigned n);
      longint unsigned rem, res, bit_w;
      rem = n;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > rem) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
        if (rem >= res + bit_w) begin
          rem = rem - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
      return res;
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint onto_shell(longint v, longint unsigned len);
      longint unsigned q;
      q = (mag(v) * longint'(radius)) / len;
      return sat32(v < 0 ? -longint'(q) : longint'(q));
    endfunction

    function v3_t shell_mid(v3_t p, v3_t q);
      v3_t m, r;
      longint unsigned len;
      // arithmetic shift gives floor of the half
      m.x = (p.x + q.x) >>> 1;
      m.y = (p.y + q.y) >>> 1;
      m.z = (p.z + q.z) >>> 1;
      len = root64(mag(m.x) * mag(m.x) + mag(m.y) * mag(m.y) + mag(m.z) * mag(m.z));
      if (len == 0) begin
        r = '{0, 0, 0};
        return r;
      end
      r.x = onto_shell(m.x, len);
      r.y = onto_shell(m.y, len);
      r.z = onto_shell(m.z, len);
      return r;
    endfunction

    function void split(v3_t a, v3_t b, v3_t c, int lvl);
      v3_t ma, mb, mc;
      cell_t e;
      if (lvl >= top) begin
        e.lvl  = lvl[1:0];
        e.f[0] = a.x[31:0];
        e.f[1] = a.y[31:0];
        e.f[2] = a.z[31:0];
        e.f[3] = 32'(sat32(b.x - a.x));
        e.f[4] = 32'(sat32(b.y - a.y));
        e.f[5] = 32'(sat32(b.z - a.z));
        e.f[6] = 32'(sat32(c.x - a.x));
        e.f[7] = 32'(sat32(c.y - a.y));
        e.f[8] = 32'(sat32(c.z - a.z));
        e.last = 1'b0;
        pending = {pending, e};
        return;
      end
      ma = shell_mid(b, c);
      mb = shell_mid(c, a);
      mc = shell_mid(a, b);
      split(a, mb, mc, lvl + 1);
      split(ma, b, mc, lvl + 1);
      split(ma, mb, c, lvl + 1);
      split(mc, mb, ma, lvl + 1);
    endfunction

    function void note_triangle(v3_t a, v3_t b, v3_t c, int start);
      tris_seen++;
      split(a, b, c, start);
      pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_cell(cell_t got);
      cell_t e;
      cells_seen++;
      if (pending.size() == 0) begin
        $error("cell transfer with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.lvl !== e.lvl) begin
        $error("cell_level expected %0d got %0d", e.lvl, got.lvl);
        errors++;
      end
      for (int i = 0; i < 9; i++)
        if (got.f[i] !== e.f[i]) begin
          $error("%s expected %h got %h", names[i], e.f[i], got.f[i]);
          errors++;
        end
      if (got.last !== e.last) begin
        $error("last_cell expected %b got %b", e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        stall_req;
  int          cycles;

  sts_in_if  in_bus ();
  sts_out_if out_bus ();

  cell_scoreboard cells = new();

  sphere_triangle_subdivider dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_bus), .out_ch(out_bus),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Note each accepted triangle and check each accepted cell.
  always @(posedge clk) begin
    v3_t   a, b, c;
    cell_t got;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      a = '{longint'(in_bus.ax), longint'(in_bus.ay), longint'(in_bus.az)};
      b = '{longint'(in_bus.bx), longint'(in_bus.by_coord), longint'(in_bus.bz)};
      c = '{longint'(in_bus.cx), longint'(in_bus.cy), longint'(in_bus.cz)};
      cells.note_triangle(a, b, c, int'(in_bus.start_level));
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.lvl  = out_bus.cell_level;
      got.f[0] = out_bus.origin_x;
      got.f[1] = out_bus.origin_y;
      got.f[2] = out_bus.origin_z;
      got.f[3] = out_bus.edge1_x;
      got.f[4] = out_bus.edge1_y;
      got.f[5] = out_bus.edge1_z;
      got.f[6] = out_bus.edge2_x;
      got.f[7] = out_bus.edge2_y;
      got.f[8] = out_bus.edge2_z;
      got.last = out_bus.last_cell;
      cells.check_cell(got);
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random ready pattern, one long hold-off on request.
  initial begin
    int n;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall_req) begin
        out_bus.ready <= 1'b0;
        for (int i = 0; i < LONG_HOLD; i++) @(posedge clk);
        stall_req = 1'b0;
      end
      n = $urandom_range(1, 40);
      out_bus.ready <= 1'b1;
      for (int i = 0; i < n; i++) @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        out_bus.ready <= 1'b0;
        for (int i = 0; i < n; i++) @(posedge clk);
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == CFG_ADDR_RADIUS) cells.radius = longint'(data[30:0]);
    else if (addr == CFG_ADDR_LEVEL)
      cells.top = (int'(data[1:0]) > STOP_DEPTH) ? STOP_DEPTH : int'(data[1:0]);
  endtask

  // Offer one triangle and hold it until the transfer; then drop valid for a random gap, sometimes none.
  task automatic send_tri(input v3_t a, input v3_t b, input v3_t c, input int start);
    int n;
    in_bus.valid       <= 1'b1;
    in_bus.ax          <= a.x[31:0];
    in_bus.ay          <= a.y[31:0];
    in_bus.az          <= a.z[31:0];
    in_bus.bx          <= b.x[31:0];
    in_bus.by_coord    <= b.y[31:0];
    in_bus.bz          <= b.z[31:0];
    in_bus.cx          <= c.x[31:0];
    in_bus.cy          <= c.y[31:0];
    in_bus.cz          <= c.z[31:0];
    in_bus.start_level <= start[1:0];
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    n = gap_len();
    if (n > 0) begin
      in_bus.valid <= 1'b0;
      for (int i = 0; i < n; i++) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (cells.pending.size() != 0) @(posedge clk);
    for (int i = 0; i < 20; i++) @(posedge clk);
  endtask

  function automatic longint rand_coord();
    logic [31:0] r;
    case ($urandom_range(0, 7))
      0: r = 32'h8000_0000;
      1: r = 32'h7fff_ffff;
      2: r = 32'h0;
      3, 4: r = $urandom;
      default: begin
        r = $urandom_range(0, 32'h0100_0000);
        if ($urandom_range(0, 1)) r = -r;
      end
    endcase
    return longint'(signed'(r));
  endfunction

  function automatic v3_t rand_vec();
    v3_t v;
    v.x = rand_coord();
    v.y = rand_coord();
    v.z = rand_coord();
    return v;
  endfunction

  // Start level mostly near the stop level so most triangles split little.
  function automatic int rand_start();
    int r, k;
    r = $urandom_range(0, 99);
    k = (r < 40) ? 0 : (r < 85) ? 1 : (r < 98) ? 2 : 3;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 3);
    return (cells.top - k < 0) ? 0 : cells.top - k;
  endfunction

  initial begin
    v3_t         hi, lo, zero, p, q;
    logic [31:0] radius_set[5] = '{32'h0d92_4ccd, 32'h0, 32'hffff_ffff, 32'h0001_0000, 32'h0};
    logic [31:0] level_set[5]  = '{32'h3, 32'h0, 32'h7, 32'h2, 32'h1};
    cycles      = 0;
    stall_req   = 1'b0;
    rst_n       <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    in_bus.valid <= 1'b0;
    in_bus.ax <= '0; in_bus.ay <= '0; in_bus.az <= '0;
    in_bus.bx <= '0; in_bus.by_coord <= '0; in_bus.bz <= '0;
    in_bus.cx <= '0; in_bus.cy <= '0; in_bus.cz <= '0;
    in_bus.start_level <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    hi   = '{64'sd2147483647, 64'sd2147483647, 64'sd2147483647};
    lo   = '{-64'sd2147483648, -64'sd2147483648, -64'sd2147483648};
    zero = '{0, 0, 0};
    p    = '{64'sd65536000, -64'sd3000000, 64'sd12345678};
    q    = '{-p.x, -p.y, -p.z};

    // Directed part at reset settings, then at max_level 1: extremes, saturating edges, zero midpoints.
    send_tri(lo, hi, zero, 3);
    send_tri(hi, lo, lo, 3);
    send_tri(zero, zero, zero, 2);
    send_tri(p, q, hi, 2);
    send_tri(lo, hi, p, 2);
    send_tri(hi, hi, lo, 1);
    send_tri(p, q, zero, 0);
    drain();
    reg_write(CFG_ADDR_LEVEL, 32'h1);
    send_tri(hi, lo, p, 3);
    send_tri(lo, lo, hi, 2);
    send_tri(p, hi, q, 0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      reg_write(CFG_ADDR_RADIUS, radius_set[ph] | ((ph == 4) ? $urandom : 32'h0));
      reg_write(CFG_ADDR_LEVEL, level_set[ph]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == 5) stall_req = 1'b1;
        if (i == 25) drain();
        send_tri(rand_vec(), rand_vec(), rand_vec(), rand_start());
      end
      drain();
    end

    for (int i = 0; i < 100; i++) @(posedge clk);
    $display("covered %0d triangles, %0d cells checked over 7 register settings",
             cells.tris_seen, cells.cells_seen);
    $display("included saturating edges, zero midpoints, stalls and full-depth splits");
    if (cells.errors == 0 && cells.pending.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/sts_pkg.sv
rtl/sts_in_if.sv
rtl/sts_out_if.sv
rtl/sts_front.sv
rtl/sts_mid.sv
rtl/sts_back.sv
rtl/sphere_triangle_subdivider.sv
sim/testbench.sv
